FILE: design/wrr_pkg.sv
// Shared widths, codes and types for the wrapping RAM with range operations.
package wrr_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int WORD_BITS_DEF = 32;

	localparam int FUNC_W   = 3;
	localparam int ADDR_W   = 32;
	localparam int OFFSET_W = 10;
	localparam int LEN_W    = 11;
	localparam int DATA_W   = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_READ  = 3'd0,
		FN_WRITE = 3'd1,
		FN_CLEAR = 3'd2,
		FN_COUNT = 3'd3,
		FN_TEST  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [LEN_W-1:0]  zero_count;
		logic              all_zero;
		logic              status;
	} result_t;

endpackage

FILE: design/wrr_if.sv
// Request and result channel interfaces.
interface wrr_req_if import wrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [ADDR_W-1:0]   address;
	logic [OFFSET_W-1:0] offset;
	logic [LEN_W-1:0]    length;
	logic [DATA_W-1:0]   write_data;

	modport source(output valid, func, address, offset, length, write_data, input ready);
	modport sink(input valid, func, address, offset, length, write_data, output ready);
endinterface

interface wrr_rsp_if import wrr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [LEN_W-1:0]  zero_count;
	logic              all_zero;
	logic              status;

	modport source(output valid, read_data, zero_count, all_zero, status, input ready);
	modport sink(input valid, read_data, zero_count, all_zero, status, output ready);
endinterface

FILE: design/wrapping_ram_range_ops.sv
// Wrapping word RAM with single-word access and clear, count-zero and all-zero range walks.
// Usage: after reset the block zeroes its memory, one word a cycle, and accepts no request
// until then. All traffic then goes through one memory port with a registered read: a write
// is done when it is taken, a read issues the address and then returns the data, a clear writes
// the range word by word, and a count or all-zero test reads it word by word and then forms the
// result; refused requests and zero-length ranges are answered with no memory access. One
// request is in work at a time, and the next is taken once the block is idle again, provided
// the result register is empty or its word is taken in that same cycle; a result word left
// waiting holds off the request port. Addresses wrap modulo DEPTH, which must be a power of two.
module wrapping_ram_range_ops import wrr_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wrr_req_if.sink   req,
	wrr_rsp_if.source rsp
);

	logic                     mem_we;
	logic                     mem_re;
	logic [$clog2(DEPTH)-1:0] mem_addr;
	logic [WORD_BITS-1:0]     mem_wdata;
	logic [WORD_BITS-1:0]     mem_rdata;

	wrr_ctrl #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	wrr_mem #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

FILE: design/wrr_mem.sv
// Single-port word memory with a registered read.
module wrr_mem import wrr_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WORD_BITS-1:0]     wdata,
	output logic [WORD_BITS-1:0]     rdata
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: design/wrr_ctrl.sv
// Request decode, range walk sequencer and result register.
module wrr_ctrl import wrr_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	wrr_req_if.sink                  req,
	wrr_rsp_if.source                rsp,
	output logic                     mem_we,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_addr,
	output logic [WORD_BITS-1:0]     mem_wdata,
	input  logic [WORD_BITS-1:0]     mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

	state_t            state_q, state_d;
	logic [AW-1:0]     init_addr_q;
	logic [AW-1:0]     addr_q;
	logic [LEN_W-1:0]  rem_q;
	func_t             op_q;
	logic [LEN_W-1:0]  zc_q;
	logic              nz_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              acc;
	logic              slot_free;
	logic              refused;
	logic              too_long;
	logic              off_bad;
	logic              len_zero;
	logic              len_one;
	logic [AW-1:0]     start;
	logic [AW-1:0]     single_addr;
	func_t             fn;
	logic              load_out;
	result_t           out_d;
	logic              rd_zero;

	assign fn          = func_t'(req.func);
	assign start       = req.address[AW-1:0];
	assign single_addr = start + AW'(req.offset);
	assign too_long    = CW'(req.length) > CW'(DEPTH);
	assign off_bad     = LEN_W'(req.offset) >= req.length;
	assign len_zero    = req.length == '0;
	assign len_one     = req.length == LEN_W'(1);
	assign refused     = (req.func > FN_TEST) || too_long ||
	                     ((fn == FN_READ || fn == FN_WRITE) && off_bad);
	assign rd_zero     = mem_rdata == '0;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (init_addr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc && !refused) begin
					unique case (fn)
						FN_READ: state_d = ST_DRAIN;
						FN_CLEAR: begin
							if (!len_zero && !len_one) state_d = ST_WALK;
						end
						FN_COUNT, FN_TEST: begin
							if (len_one) state_d = ST_DRAIN;
							else if (!len_zero) state_d = ST_WALK;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (rem_q == LEN_W'(1)) state_d = (op_q == FN_CLEAR) ? ST_IDLE : ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory commands and result
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		load_out  = 1'b0;
		out_d     = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we   = 1'b1;
				mem_addr = init_addr_q;
			end
			ST_IDLE: begin
				if (acc) begin
					if (refused) begin
						load_out     = 1'b1;
						out_d.status = 1'b1;
					end else begin
						unique case (fn)
							FN_READ: begin
								mem_re   = 1'b1;
								mem_addr = single_addr;
							end
							FN_WRITE: begin
								mem_we    = 1'b1;
								mem_addr  = single_addr;
								mem_wdata = WORD_BITS'(req.write_data);
								load_out  = 1'b1;
							end
							FN_CLEAR: begin
								mem_we   = !len_zero;
								mem_addr = start;
								load_out = len_zero || len_one;
							end
							FN_COUNT, FN_TEST: begin
								mem_re         = !len_zero;
								mem_addr       = start;
								load_out       = len_zero;
								out_d.all_zero = fn == FN_TEST;
							end
							default: begin
								load_out     = 1'b1;
								out_d.status = 1'b1;
							end
						endcase
					end
				end
			end
			ST_WALK: begin
				mem_addr = addr_q;
				if (op_q == FN_CLEAR) begin
					mem_we   = 1'b1;
					load_out = rem_q == LEN_W'(1);
				end else begin
					mem_re = 1'b1;
				end
			end
			ST_DRAIN: begin
				load_out = 1'b1;
				unique case (op_q)
					FN_READ:  out_d.read_data  = DATA_W'(mem_rdata);
					FN_COUNT: out_d.zero_count = zc_q + LEN_W'(rd_zero);
					FN_TEST:  out_d.all_zero   = !nz_q && rd_zero;
					default:  out_d            = '0;
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) init_addr_q <= init_addr_q + AW'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// walk registers: address of the next word, words left, running tallies
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= fn;
			addr_q <= start + AW'(1);
			rem_q  <= req.length - LEN_W'(1);
			zc_q   <= '0;
			nz_q   <= 1'b0;
		end else if (state_q == ST_WALK) begin
			addr_q <= addr_q + AW'(1);
			rem_q  <= rem_q - LEN_W'(1);
			zc_q   <= zc_q + LEN_W'(rd_zero);
			nz_q   <= nz_q || !rd_zero;
		end
		if (load_out) out_q <= out_d;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_q.read_data;
	assign rsp.zero_count = out_q.zero_count;
	assign rsp.all_zero   = out_q.all_zero;
	assign rsp.status     = out_q.status;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("result word overwritten before it was taken");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write in the same cycle");

	a_drain_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(mem_re))
		else $error("drain without a read issued the cycle before");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> rem_q != '0)
		else $error("range walk with no words left");

endmodule
